/* hw/rtl/ttbl_pkg.sv */
package ttbl_pkg;

  localparam int TABLE_COLUMNS = 7;
  localparam int TABLE_ROWS    = 7;
  localparam int CELL_KINDS    = 3;
  localparam int TABLE_KINDS   = 4;
  localparam int TABLE_SIZE    = TABLE_COLUMNS * TABLE_ROWS;
  localparam int STORE_SIZE    = CELL_KINDS * TABLE_KINDS * TABLE_SIZE;

  localparam int COL_AW   = $clog2(TABLE_COLUMNS);
  localparam int ROW_AW   = $clog2(TABLE_ROWS);
  localparam int STORE_AW = $clog2(STORE_SIZE);

  // The breakpoint scan reads one entry a cycle; its compare works on the registered read data.
  localparam int SCAN_LEN = (TABLE_COLUMNS > TABLE_ROWS) ? TABLE_COLUMNS : TABLE_ROWS;
  // Quotient bits produced by the divider once overflow is ruled out.
  localparam int DIV_BITS = 33;
  localparam int CNT_W    = 6;

  localparam logic [1:0] ACT_CAP   = 2'd0;
  localparam logic [1:0] ACT_SLEW  = 2'd1;
  localparam logic [1:0] ACT_TBL   = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EQUAL = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  localparam logic [1:0] LERP_A = 2'd0;
  localparam logic [1:0] LERP_B = 2'd1;
  localparam logic [1:0] LERP_R = 2'd2;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_SCAN   = 4'd1;
  localparam logic [3:0] OP_BP     = 4'd2;
  localparam logic [3:0] OP_TBL    = 4'd3;
  localparam logic [3:0] OP_EQ     = 4'd4;
  localparam logic [3:0] OP_PREP   = 4'd5;
  localparam logic [3:0] OP_MUL    = 4'd6;
  localparam logic [3:0] OP_SUM    = 4'd7;
  localparam logic [3:0] OP_DIVCHK = 4'd8;
  localparam logic [3:0] OP_DIV    = 4'd9;
  localparam logic [3:0] OP_ADD    = 4'd10;

  typedef struct packed {
    logic             load;
    logic [3:0]       op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       sel;
  } cmd_t;

  typedef struct packed {
    logic query_ok;
    logic bp_equal;
    logic div_ovf;
  } sts_t;

  function automatic logic [STORE_AW-1:0] tbl_addr(input logic [1:0] ck,
                                                   input logic [1:0] tk,
                                                   input int off);
    int a;
    a = (int'(ck) * TABLE_KINDS + int'(tk)) * TABLE_SIZE + off;
    return STORE_AW'(a);
  endfunction

endpackage

/* hw/rtl/ttbl_if.sv */
interface ttbl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [1:0]         cell_kind;
  logic [1:0]         table_kind;
  logic [5:0]         entry;
  logic signed [31:0] write_value;
  logic signed [31:0] load_cap;
  logic signed [31:0] input_slew;

  modport source (output valid, action, cell_kind, table_kind, entry, write_value,
                  load_cap, input_slew, input ready);
  modport sink (input valid, action, cell_kind, table_kind, entry, write_value,
                load_cap, input_slew, output ready);
endinterface

interface ttbl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interpolated_value;
  logic [1:0]         status;

  modport source (output valid, interpolated_value, status, input ready);
  modport sink (input valid, interpolated_value, status, output ready);
endinterface

/* hw/rtl/ttbl_ram.sv */
module ttbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ttbl_dp.sv */
module ttbl_dp (
  input  logic                clk,
  input  ttbl_pkg::cmd_t      cmd,
  output ttbl_pkg::sts_t      sts,
  input  logic [1:0]          action,
  input  logic [1:0]          cell_kind,
  input  logic [1:0]          table_kind,
  input  logic [5:0]          entry,
  input  logic signed [31:0]  write_value,
  input  logic signed [31:0]  load_cap,
  input  logic signed [31:0]  input_slew,
  output logic signed [31:0]  interpolated_value,
  output logic [1:0]          status
);
  import ttbl_pkg::*;

  logic [1:0]       ck_q, tk_q;
  logic [31:0]      cap_q, slew_q;
  logic [CNT_W-1:0] cf, rf;
  logic [31:0]      c0, c1, s0, s1;
  logic [31:0]      p00, p10, p01, p11;
  logic [31:0]      ra, rb, res;
  logic             sat, eq;

  logic [32:0]      mdp, mdx, mden;
  logic             neg;
  logic [31:0]      base;
  logic [63:0]      prod_lo;
  logic [65:0]      prod;
  logic             ovf_q;
  logic [33:0]      rem;
  logic [32:0]      dvd;
  logic [32:0]      quo;

  logic                cap_we, slew_we, tbl_we;
  logic [COL_AW-1:0]   cap_raddr;
  logic [ROW_AW-1:0]   slew_raddr;
  logic [STORE_AW-1:0] tbl_waddr, tbl_raddr;
  logic [31:0]         cap_rdata, slew_rdata, tbl_rdata;
  logic [COL_AW-1:0]   ci, ci_lo;
  logic [ROW_AW-1:0]   ri, ri_lo;
  logic                kinds_ok;

  assign kinds_ok = (int'(cell_kind) < CELL_KINDS) && (int'(table_kind) < TABLE_KINDS);
  assign cap_we   = cmd.load && (action == ACT_CAP) && (int'(entry) < TABLE_COLUMNS);
  assign slew_we  = cmd.load && (action == ACT_SLEW) && (int'(entry) < TABLE_ROWS);
  assign tbl_we   = cmd.load && (action == ACT_TBL) && kinds_ok &&
                    (int'(entry) < TABLE_SIZE);
  assign tbl_waddr = tbl_addr(cell_kind, table_kind, int'(entry));

  assign sts.query_ok = (action == ACT_QUERY) && kinds_ok;
  assign sts.bp_equal = (c0 == c1) || (s0 == s1);
  assign sts.div_ovf  = prod[65:33] >= mden;

  // Clamp the first-above index into 1..size-1.
  always_comb begin
    if (cf == '0) begin
      ci = COL_AW'(1);
    end else if (cf >= CNT_W'(TABLE_COLUMNS)) begin
      ci = COL_AW'(TABLE_COLUMNS - 1);
    end else begin
      ci = cf[COL_AW-1:0];
    end
    if (rf == '0) begin
      ri = ROW_AW'(1);
    end else if (rf >= CNT_W'(TABLE_ROWS)) begin
      ri = ROW_AW'(TABLE_ROWS - 1);
    end else begin
      ri = rf[ROW_AW-1:0];
    end
    ci_lo = ci - COL_AW'(1);
    ri_lo = ri - ROW_AW'(1);
  end

  always_comb begin
    cap_raddr  = '0;
    slew_raddr = '0;
    tbl_raddr  = '0;
    case (cmd.op)
      OP_SCAN: begin
        if (cmd.cnt < CNT_W'(TABLE_COLUMNS)) cap_raddr = cmd.cnt[COL_AW-1:0];
        if (cmd.cnt < CNT_W'(TABLE_ROWS)) slew_raddr = cmd.cnt[ROW_AW-1:0];
      end
      OP_BP: begin
        cap_raddr  = (cmd.cnt == '0) ? ci_lo : ci;
        slew_raddr = (cmd.cnt == '0) ? ri_lo : ri;
      end
      OP_TBL: begin
        case (cmd.cnt[1:0])
          2'd0: tbl_raddr = tbl_addr(ck_q, tk_q, int'(ci_lo) + TABLE_COLUMNS * int'(ri_lo));
          2'd1: tbl_raddr = tbl_addr(ck_q, tk_q, int'(ci_lo) + TABLE_COLUMNS * int'(ri));
          2'd2: tbl_raddr = tbl_addr(ck_q, tk_q, int'(ci) + TABLE_COLUMNS * int'(ri_lo));
          default: tbl_raddr = tbl_addr(ck_q, tk_q, int'(ci) + TABLE_COLUMNS * int'(ri));
        endcase
      end
      default: ;
    endcase
  end

  ttbl_ram #(.WIDTH(32), .DEPTH(TABLE_COLUMNS)) u_cap_ram (
    .clk(clk), .we(cap_we), .waddr(entry[COL_AW-1:0]), .wdata(write_value),
    .raddr(cap_raddr), .rdata(cap_rdata)
  );

  ttbl_ram #(.WIDTH(32), .DEPTH(TABLE_ROWS)) u_slew_ram (
    .clk(clk), .we(slew_we), .waddr(entry[ROW_AW-1:0]), .wdata(write_value),
    .raddr(slew_raddr), .rdata(slew_rdata)
  );

  ttbl_ram #(.WIDTH(32), .DEPTH(STORE_SIZE)) u_tbl_ram (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(write_value),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  // Operand selection for the three interpolation steps.
  logic [31:0] sel_base, sel_hi;
  logic [32:0] sel_dp, sel_dx, sel_den;

  always_comb begin
    case (cmd.sel)
      LERP_A: begin
        sel_base = p00;
        sel_hi   = p10;
      end
      LERP_B: begin
        sel_base = p01;
        sel_hi   = p11;
      end
      default: begin
        sel_base = ra;
        sel_hi   = rb;
      end
    endcase
    sel_dp = {sel_hi[31], sel_hi} - {sel_base[31], sel_base};
    if (cmd.sel == LERP_R) begin
      sel_dx  = {cap_q[31], cap_q} - {c0[31], c0};
      sel_den = {c1[31], c1} - {c0[31], c0};
    end else begin
      sel_dx  = {slew_q[31], slew_q} - {s0[31], s0};
      sel_den = {s1[31], s1} - {s0[31], s0};
    end
  end

  logic [33:0] trial;
  logic [34:0] sum35;
  logic [31:0] step_res;
  logic        step_sat;

  assign trial = {rem[32:0], dvd[32]};

  always_comb begin
    if (neg) begin
      sum35 = {{3{base[31]}}, base} - {2'b00, quo};
    end else begin
      sum35 = {{3{base[31]}}, base} + {2'b00, quo};
    end
    if (ovf_q) begin
      step_sat = 1'b1;
      step_res = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (sum35[34:31] != 4'b0000 && sum35[34:31] != 4'b1111) begin
      step_sat = 1'b1;
      step_res = sum35[34] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      step_sat = 1'b0;
      step_res = sum35[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ck_q   <= cell_kind;
      tk_q   <= table_kind;
      cap_q  <= load_cap;
      slew_q <= input_slew;
      sat    <= 1'b0;
      eq     <= 1'b0;
    end
    case (cmd.op)
      OP_SCAN: begin
        if (cmd.cnt == '0) begin
          cf <= CNT_W'(TABLE_COLUMNS);
          rf <= CNT_W'(TABLE_ROWS);
        end else begin
          if (cmd.cnt <= CNT_W'(TABLE_COLUMNS) && cf == CNT_W'(TABLE_COLUMNS) &&
              $signed(cap_q) < $signed(cap_rdata)) begin
            cf <= cmd.cnt - CNT_W'(1);
          end
          if (cmd.cnt <= CNT_W'(TABLE_ROWS) && rf == CNT_W'(TABLE_ROWS) &&
              $signed(slew_q) < $signed(slew_rdata)) begin
            rf <= cmd.cnt - CNT_W'(1);
          end
        end
      end
      OP_BP: begin
        if (cmd.cnt == CNT_W'(1)) begin
          c0 <= cap_rdata;
          s0 <= slew_rdata;
        end else if (cmd.cnt == CNT_W'(2)) begin
          c1 <= cap_rdata;
          s1 <= slew_rdata;
        end
      end
      OP_TBL: begin
        case (cmd.cnt[2:0])
          3'd1: p00 <= tbl_rdata;
          3'd2: p10 <= tbl_rdata;
          3'd3: p01 <= tbl_rdata;
          3'd4: p11 <= tbl_rdata;
          default: ;
        endcase
      end
      OP_EQ: eq <= 1'b1;
      OP_PREP: begin
        mdp  <= sel_dp[32] ? -sel_dp : sel_dp;
        mdx  <= sel_dx[32] ? -sel_dx : sel_dx;
        mden <= sel_den[32] ? -sel_den : sel_den;
        neg  <= sel_dp[32] ^ sel_dx[32] ^ sel_den[32];
        base <= sel_base;
      end
      OP_MUL: prod_lo <= mdp[31:0] * mdx[31:0];
      OP_SUM: begin
        prod <= {2'b00, prod_lo}
              + (mdp[32] ? {2'b00, mdx[31:0], 32'b0} : 66'b0)
              + (mdx[32] ? {2'b00, mdp[31:0], 32'b0} : 66'b0)
              + ((mdp[32] && mdx[32]) ? {2'b01, 64'b0} : 66'b0);
      end
      OP_DIVCHK: begin
        ovf_q <= sts.div_ovf;
        rem   <= {1'b0, prod[65:33]};
        dvd   <= prod[32:0];
        quo   <= '0;
      end
      OP_DIV: begin
        if (trial >= {1'b0, mden}) begin
          rem <= trial - {1'b0, mden};
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[31:0], 1'b0};
        end
        dvd <= {dvd[31:0], 1'b0};
      end
      OP_ADD: begin
        if (step_sat) sat <= 1'b1;
        case (cmd.sel)
          LERP_A: ra <= step_res;
          LERP_B: rb <= step_res;
          default: res <= step_res;
        endcase
      end
      default: ;
    endcase
  end

  assign interpolated_value = eq ? 32'sd0 : $signed(res);
  assign status = eq ? STAT_EQUAL : (sat ? STAT_SAT : STAT_OK);

endmodule

/* hw/rtl/ttbl_ctrl.sv */
module ttbl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ttbl_pkg::cmd_t cmd,
  input  ttbl_pkg::sts_t sts
);
  import ttbl_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_BP     = 4'd2;
  localparam logic [3:0] ST_TBL    = 4'd3;
  localparam logic [3:0] ST_CHECK  = 4'd4;
  localparam logic [3:0] ST_PREP   = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_SUM    = 4'd7;
  localparam logic [3:0] ST_DIVCHK = 4'd8;
  localparam logic [3:0] ST_DIV    = 4'd9;
  localparam logic [3:0] ST_ADD    = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       sel, sel_next;
  logic             load;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign load      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + CNT_W'(1);
    sel_next   = sel;
    cmd.load   = load;
    cmd.op     = OP_NONE;
    cmd.cnt    = cnt;
    cmd.sel    = sel;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (load && sts.query_ok) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.op = OP_SCAN;
        if (cnt == CNT_W'(SCAN_LEN)) begin
          state_next = ST_BP;
          cnt_next   = '0;
        end
      end
      ST_BP: begin
        cmd.op = OP_BP;
        if (cnt == CNT_W'(2)) begin
          state_next = ST_TBL;
          cnt_next   = '0;
        end
      end
      ST_TBL: begin
        cmd.op = OP_TBL;
        if (cnt == CNT_W'(4)) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        sel_next = LERP_A;
        if (sts.bp_equal) begin
          cmd.op     = OP_EQ;
          state_next = ST_OUT;
        end else begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.op     = OP_PREP;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op     = OP_MUL;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op     = OP_SUM;
        state_next = ST_DIVCHK;
      end
      ST_DIVCHK: begin
        cmd.op     = OP_DIVCHK;
        cnt_next   = '0;
        state_next = sts.div_ovf ? ST_ADD : ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt == DIV_LAST) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.op = OP_ADD;
        if (sel == LERP_R) begin
          state_next = ST_OUT;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = ST_PREP;
        end
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sel   <= LERP_A;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (load && sts.query_ok) |=> (state == ST_SCAN))
    else $error("query did not start the scan");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt <= DIV_LAST))
    else $error("divider ran past its last quotient bit");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

endmodule

/* hw/rtl/timing_table_bilinear_lookup.sv */
// Channel  Dir  Payload
// req      in   action, cell_kind, table_kind, entry, write_value, load_cap, input_slew
// rsp      out  interpolated_value, status
//
// Write beats (breakpoints and table entries) leave the block idle.
// A query beat runs a breakpoint scan, fetches the neighboring breakpoints and
// table entries, then, unless a neighboring pair is equal, runs three interpolation
// steps that all share one divider producing one quotient bit per cycle.
// Reset is synchronous and clears only the controller; the stores hold garbage
// until written. A stalled result simply holds; no new beat is taken until it leaves.
module timing_table_bilinear_lookup (
  input logic       clk,
  input logic       rst,
  ttbl_in_if.sink   req,
  ttbl_out_if.source rsp
);
  import ttbl_pkg::*;

  // The controller sequences the query; the datapath owns the stores and arithmetic.
  cmd_t cmd;
  sts_t sts;

  ttbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Query results stay in datapath registers until the response beat is taken.
  ttbl_dp u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .sts                (sts),
    .action             (req.action),
    .cell_kind          (req.cell_kind),
    .table_kind         (req.table_kind),
    .entry              (req.entry),
    .write_value        (req.write_value),
    .load_cap           (req.load_cap),
    .input_slew         (req.input_slew),
    .interpolated_value (rsp.interpolated_value),
    .status             (rsp.status)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ttbl_pkg::*;

  // One expected response beat: the interpolated value and its status code.
  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } lookup_result_t;

  logic clk;
  logic rst;

  ttbl_in_if  req ();
  ttbl_out_if rsp ();

  timing_table_bilinear_lookup u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow copies of the three stores. They are filled completely before the
  // first query, so no query ever reads an entry that was never written.
  logic signed [31:0] cap_bp  [TABLE_COLUMNS];
  logic signed [31:0] slew_bp [TABLE_ROWS];
  logic signed [31:0] tbl_mem [STORE_SIZE];

  lookup_result_t pending_lookups[$];
  int  error_count = 0;
  bit  sender_busy_mode;   // when set, the sender never inserts gaps
  bit  sink_busy_mode;     // when set, the response side never stalls
  int  sink_stall;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Linear step base + dp*dx/den, with the quotient truncated toward zero and
  // the sum clamped to 32 bits. Every difference stays below 2^32 in size, so
  // the product of two magnitudes fits in 64 unsigned bits.
  function automatic longint lerp_step(input longint base, input longint dp,
                                       input longint dx, input longint den,
                                       inout bit sat);
    bit                neg;
    longint unsigned   mdp, mdx, mden, quo;
    longint            sum;
    neg  = ((dp < 0) != (dx < 0)) != (den < 0);
    mdp  = (dp < 0) ? -dp : dp;
    mdx  = (dx < 0) ? -dx : dx;
    mden = (den < 0) ? -den : den;
    quo  = (mdp * mdx) / mden;
    if (quo >= 64'h2_0000_0000) begin
      sat = 1'b1;
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    sum = neg ? base - longint'(quo) : base + longint'(quo);
    if (sum > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (sum < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return sum;
  endfunction

  // First breakpoint strictly above x, clamped so that both neighbors exist.
  function automatic int upper_bp_index(input bit on_cap, input longint x);
    int n, i;
    n = on_cap ? TABLE_COLUMNS : TABLE_ROWS;
    i = 0;
    while (i < n && !(x < longint'(on_cap ? cap_bp[i] : slew_bp[i])))
      i++;
    if (i == 0)
      i = 1;
    if (i >= n)
      i = n - 1;
    return i;
  endfunction

  // Applies one accepted request beat to the shadow stores, and for a valid
  // query pushes the expected response.
  function automatic void apply_request(input logic [1:0] act, input logic [1:0] ck,
                                        input logic [1:0] tk, input logic [5:0] ent,
                                        input logic signed [31:0] wv,
                                        input logic signed [31:0] cap,
                                        input logic signed [31:0] slew);
    int             ci, ri, base;
    longint         c0, c1, s0, s1, p00, p01, p10, p11, a, b, r;
    bit             sat;
    lookup_result_t res;
    if (act == ACT_CAP) begin
      if (ent < TABLE_COLUMNS)
        cap_bp[ent] = wv;
      return;
    end
    if (act == ACT_SLEW) begin
      if (ent < TABLE_ROWS)
        slew_bp[ent] = wv;
      return;
    end
    if (ck >= CELL_KINDS || tk >= TABLE_KINDS)
      return;
    base = (int'(ck) * TABLE_KINDS + int'(tk)) * TABLE_SIZE;
    if (act == ACT_TBL) begin
      if (ent < TABLE_SIZE)
        tbl_mem[base + ent] = wv;
      return;
    end
    ci  = upper_bp_index(1'b1, longint'(cap));
    ri  = upper_bp_index(1'b0, longint'(slew));
    c0  = cap_bp[ci - 1];
    c1  = cap_bp[ci];
    s0  = slew_bp[ri - 1];
    s1  = slew_bp[ri];
    p00 = tbl_mem[base + (ci - 1) + TABLE_COLUMNS * (ri - 1)];
    p01 = tbl_mem[base + ci + TABLE_COLUMNS * (ri - 1)];
    p10 = tbl_mem[base + (ci - 1) + TABLE_COLUMNS * ri];
    p11 = tbl_mem[base + ci + TABLE_COLUMNS * ri];
    sat = 1'b0;
    if (s1 == s0 || c1 == c0) begin
      res.value  = '0;
      res.status = STAT_EQUAL;
    end else begin
      a = lerp_step(p00, p10 - p00, longint'(slew) - s0, s1 - s0, sat);
      b = lerp_step(p01, p11 - p01, longint'(slew) - s0, s1 - s0, sat);
      r = lerp_step(a, b - a, longint'(cap) - c0, c1 - c0, sat);
      res.value  = r[31:0];
      res.status = sat ? STAT_SAT : STAT_OK;
    end
    pending_lookups.push_back(res);
  endfunction

  // Sends one request beat. Valid is only lowered when a gap follows, so a
  // back-to-back beat never sees valid dropped and raised in the same step.
  task automatic send_beat(input logic [1:0] act, input logic [1:0] ck,
                           input logic [1:0] tk, input logic [5:0] ent,
                           input logic signed [31:0] wv,
                           input logic signed [31:0] cap = '0,
                           input logic signed [31:0] slew = '0);
    int gap;
    gap = sender_busy_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.action      <= act;
    req.cell_kind   <= ck;
    req.table_kind  <= tk;
    req.entry       <= ent;
    req.write_value <= wv;
    req.load_cap    <= cap;
    req.input_slew  <= slew;
    do
      @(posedge clk);
    while (!req.ready);
    apply_request(act, ck, tk, ent, wv, cap, slew);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0)
      @(posedge clk);
  endtask

  // Writes an ascending breakpoint set on one axis. With make_flat set, one
  // neighboring pair is made equal.
  task automatic load_breakpoints(input logic [1:0] act, input bit make_flat);
    int          step_max, flat_at;
    logic signed [31:0] v;
    step_max = $urandom_range(0, 3) == 0 ? 32'h0100_0000 : 32'h0010_0000;
    v        = -$signed($urandom_range(0, step_max * 2));
    flat_at  = $urandom_range(1, TABLE_COLUMNS - 1);
    for (int i = 0; i < TABLE_COLUMNS; i++) begin
      send_beat(act, 2'd0, 2'd0, 6'(i), v);
      if (!(make_flat && i + 1 == flat_at))
        v = v + $signed($urandom_range(1, step_max));
    end
  endtask

  // Random table value: mostly moderate delays, sometimes anything at all.
  function automatic logic signed [31:0] table_value();
    if ($urandom_range(0, 7) == 0)
      return $urandom;
    return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0080_0000;
  endfunction

  task automatic test_fill_stores();
    load_breakpoints(ACT_CAP, 1'b0);
    load_breakpoints(ACT_SLEW, 1'b0);
    for (int ck = 0; ck < CELL_KINDS; ck++)
      for (int tk = 0; tk < TABLE_KINDS; tk++)
        for (int e = 0; e < TABLE_SIZE; e++)
          send_beat(ACT_TBL, 2'(ck), 2'(tk), 6'(e), table_value());
  endtask

  task automatic test_directed();
    // Writes that fall outside every store are dropped, as is a query of a
    // cell kind that does not exist.
    send_beat(ACT_CAP, 2'd3, 2'd3, 6'd7, 32'sh7fff_ffff);
    send_beat(ACT_SLEW, 2'd3, 2'd3, 6'd63, 32'sh8000_0000);
    send_beat(ACT_TBL, 2'd2, 2'd3, 6'd49, 32'sh1234_5678);
    send_beat(ACT_TBL, 2'd3, 2'd0, 6'd0, 32'sh1234_5678);
    send_beat(ACT_QUERY, 2'd3, 2'd1, 6'd0, '0, '0, '0);
    // Queries at the corners of the input range, far off the grid.
    send_beat(ACT_QUERY, 2'd0, 2'd0, 6'd0, '0, 32'sh8000_0000, 32'sh8000_0000);
    send_beat(ACT_QUERY, 2'd1, 2'd1, 6'd0, '0, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_beat(ACT_QUERY, 2'd2, 2'd2, 6'd0, '0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_beat(ACT_QUERY, 2'd2, 2'd3, 6'd63, 32'hffff_ffff, 32'sh7fff_ffff,
              32'sh8000_0000);
    // Exactly on breakpoints, including the first and the last.
    send_beat(ACT_QUERY, 2'd0, 2'd3, 6'd0, '0, cap_bp[0], slew_bp[0]);
    send_beat(ACT_QUERY, 2'd1, 2'd2, 6'd0, '0, cap_bp[TABLE_COLUMNS - 1],
              slew_bp[TABLE_ROWS - 1]);
    send_beat(ACT_QUERY, 2'd0, 2'd1, 6'd0, '0, cap_bp[3], slew_bp[2]);
    // Extreme entries in one table drive the result into saturation.
    send_beat(ACT_TBL, 2'd1, 2'd0, 6'd0, 32'sh7fff_ffff);
    send_beat(ACT_TBL, 2'd1, 2'd0, 6'd1, 32'sh8000_0000);
    send_beat(ACT_TBL, 2'd1, 2'd0, 6'd7, 32'sh8000_0000);
    send_beat(ACT_QUERY, 2'd1, 2'd0, 6'd0, '0, 32'sh8000_0000, 32'sh8000_0000);
    send_beat(ACT_QUERY, 2'd1, 2'd0, 6'd0, '0, 32'sh7fff_ffff, 32'sh8000_0000);
    // Sender holds off until the block has answered everything.
    wait_drained();
    // Equal neighboring breakpoints on the capacitance axis, then on slew.
    send_beat(ACT_CAP, 2'd0, 2'd0, 6'd1, cap_bp[0]);
    send_beat(ACT_QUERY, 2'd2, 2'd0, 6'd0, '0, cap_bp[0] - 1, slew_bp[1]);
    send_beat(ACT_CAP, 2'd0, 2'd0, 6'd1, cap_bp[2] - 1);
    send_beat(ACT_SLEW, 2'd0, 2'd0, 6'd6, slew_bp[5]);
    send_beat(ACT_QUERY, 2'd0, 2'd2, 6'd0, '0, cap_bp[1], 32'sh7fff_ffff);
  endtask

  // Query point near the loaded grid most of the time, sometimes exactly on a breakpoint, anywhere otherwise.
  function automatic logic signed [31:0] axis_point(input bit on_cap);
    logic signed [31:0] lo, hi;
    lo = on_cap ? cap_bp[0] : slew_bp[0];
    hi = on_cap ? cap_bp[TABLE_COLUMNS - 1] : slew_bp[TABLE_ROWS - 1];
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return on_cap ? cap_bp[$urandom_range(0, TABLE_COLUMNS - 1)]
                       : slew_bp[$urandom_range(0, TABLE_ROWS - 1)];
      default: begin
        if (hi <= lo)
          return lo + $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        return lo - (hi - lo) / 8 +
               $signed($urandom_range(0, (hi - lo) + (hi - lo) / 4));
      end
    endcase
  endfunction

  task automatic test_random_traffic();
    int roll;
    for (int n = 0; n < 180; n++) begin
      // Stretches with no gaps on either side.
      sender_busy_mode = (n % 90) >= 75;
      sink_busy_mode   = (n % 90) >= 70 && (n % 90) < 85;
      if (n == 90)
        wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 62) begin
        send_beat(ACT_QUERY, 2'($urandom_range(0, 2)), 2'($urandom),
                  6'($urandom), $urandom, axis_point(1'b1), axis_point(1'b0));
      end else if (roll < 64) begin
        load_breakpoints(ACT_CAP, $urandom_range(0, 4) == 0);
      end else if (roll < 66) begin
        load_breakpoints(ACT_SLEW, $urandom_range(0, 4) == 0);
      end else if (roll < 90) begin
        send_beat(ACT_TBL, 2'($urandom_range(0, 2)), 2'($urandom),
                  6'($urandom_range(0, TABLE_SIZE - 1)), table_value(), $urandom,
                  $urandom);
      end else begin
        // Noise: any field value at all, including dropped writes and queries.
        send_beat(2'($urandom), 2'($urandom), 2'($urandom), 6'($urandom), $urandom,
                  $urandom, $urandom);
      end
    end
    sender_busy_mode = 1'b0;
    sink_busy_mode   = 1'b0;
  endtask

  // Response side: per beat it draws how long to hold ready low afterwards.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready  <= 1'b0;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      rsp.ready  <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      sink_stall <= sink_busy_mode ? 0 : $urandom_range(0, 14);
      rsp.ready  <= sink_busy_mode;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Each response beat is compared against the oldest outstanding query.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_lookups.size() == 0) begin
        $error("response beat with no query outstanding: value %0d status %0d",
               rsp.interpolated_value, rsp.status);
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (rsp.interpolated_value !== want.value) begin
          $error("interpolated_value: expected %0d, got %0d", want.value,
                 rsp.interpolated_value);
          error_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    sender_busy_mode = 1'b0;
    sink_busy_mode   = 1'b0;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.action       = ACT_CAP;
    req.cell_kind    = '0;
    req.table_kind   = '0;
    req.entry        = '0;
    req.write_value  = '0;
    req.load_cap     = '0;
    req.input_slew   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_stores();
    test_directed();
    test_random_traffic();

    wait_drained();
    // Leave room for any stray response.
    repeat (300) @(posedge clk);
    if (pending_lookups.size() != 0)
      $error("%0d expected responses never arrived", pending_lookups.size());
    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // If every one of the roughly 850 beats were a query under the longest gaps
  // and stalls, the run would take near 1.4 ms in all; 5 ms is several times that.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ttbl_pkg.sv
hw/rtl/ttbl_if.sv
hw/rtl/ttbl_ram.sv
hw/rtl/ttbl_dp.sv
hw/rtl/ttbl_ctrl.sv
hw/rtl/timing_table_bilinear_lookup.sv
test/tb_top.sv
